>>> design/mfd_pkg.sv
// Package for the multi-format to binary32 decoder.
// Format codes, constants and the per-format decode functions; no dependencies.
package mfd_pkg;

    typedef enum logic [2:0] {
        FMT_F32   = 3'd0,
        FMT_F16   = 3'd1,
        FMT_BF16  = 3'd2,
        FMT_I32   = 3'd3,
        FMT_E4M3  = 3'd4,
        FMT_E8M0  = 3'd5,
        FMT_RSV6  = 3'd6,
        FMT_RSV7  = 3'd7
    } fmt_t;

    localparam logic [31:0] CANON_QNAN = 32'h7fc0_0000;
    localparam logic [31:0] EXP_ALL    = 32'h7f80_0000;
    localparam logic [31:0] QUIET_BIT  = 32'h0040_0000;
    localparam logic        STATUS_OK  = 1'b0;
    localparam logic        STATUS_UNSUPPORTED = 1'b1;

    function automatic logic [31:0] dec_f16(input logic [15:0] h);
        logic [4:0]  e;
        logic [9:0]  m;
        logic [3:0]  s;
        logic [10:0] mn;
        logic [31:0] r;
        e = h[14:10];
        m = h[9:0];
        s = 4'd0;
        mn = {1'b0, m};
        r = {h[15], 31'd0};
        if (e == 5'd0) begin
            if (m != 10'd0) begin
                // Normalizing shift: leading-zero count over the 10-bit fraction, plus one.
                for (int i = 9; i >= 0; i--) begin
                    if (m[i] && s == 4'd0 && mn[10] == 1'b0) begin
                        s = 4'(10 - i);
                        mn = 11'({1'b0, m} << (10 - i));
                    end
                end
                r = {h[15], 8'(8'd113 - {4'd0, s}), mn[9:0], 13'd0};
            end
        end else if (e == 5'h1f) begin
            r = {h[15], 8'hff, m, 13'd0};
            if (m != 10'd0) begin
                r = r | QUIET_BIT;
            end
        end else begin
            r = {h[15], 8'({3'd0, e} + 8'd112), m, 13'd0};
        end
        return r;
    endfunction

    function automatic logic [31:0] dec_e4m3(input logic [7:0] b);
        logic [3:0]  e;
        logic [2:0]  m;
        logic [31:0] r;
        e = b[6:3];
        m = b[2:0];
        r = {b[7], 31'd0};
        if (b[6:0] == 7'h7f) begin
            r = CANON_QNAN;
        end else if (e == 4'd0) begin
            if (m[2]) begin
                r = {b[7], 8'd120, m[1:0], 1'b0, 20'd0};
            end else if (m[1]) begin
                r = {b[7], 8'd119, m[0], 2'b00, 20'd0};
            end else if (m[0]) begin
                r = {b[7], 8'd118, 23'd0};
            end
        end else begin
            r = {b[7], 8'({4'd0, e} + 8'd120), m, 20'd0};
        end
        return r;
    endfunction

    function automatic logic [31:0] dec_e8m0(input logic [7:0] b);
        logic [31:0] r;
        if (b == 8'hff) begin
            r = CANON_QNAN;
        end else if (b == 8'd0) begin
            r = QUIET_BIT;
        end else begin
            r = {1'b0, b, 23'd0};
        end
        return r;
    endfunction

endpackage

>>> design/multi_format_to_binary32_decoder_core.sv
// Multi-format scalar decoder to IEEE binary32, top level.
// The result strobe is registered and rises in the cycle after the start transaction is taken.
// Throughput: one transaction per cycle; busy is held low, the receiver cannot stall.
// The integer path is a priority encode, a barrel shift and a 24-bit round add.
// Reset (rst_n, asynchronous, active low) clears the result strobe.
// Depends on mfd_pkg.
module multi_format_to_binary32_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  action,
    input  logic [31:0] source_bits,
    output logic        done,
    output logic [31:0] value_bits,
    output logic        status
);

    logic        done_reg;
    logic [31:0] value_reg, value_next;
    logic        status_reg, status_next;

    logic [31:0] mag;
    logic [4:0]  p;
    logic [31:0] norm;
    logic [24:0] q;
    logic [31:0] i32_val;

    assign busy = 1'b0;

    // Integer conversion: normalize so the leading one lands in bit 31, then round.
    always_comb
    begin
        mag = source_bits[31] ? (32'd0 - source_bits) : source_bits;
        p = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (mag[i]) begin
                p = 5'(i);
            end
        end
        norm = mag << (5'd31 - p);
        q = {1'b0, norm[31:8]};
        if (norm[7] && ((norm[6:0] != 7'd0) || norm[8])) begin
            q = q + 25'd1;
        end
        i32_val = {source_bits[31], 31'd0}
                | ({1'b0, 8'(8'd126 + {3'd0, p}), 23'd0} + {7'd0, q});
        if (mag == 32'd0) begin
            i32_val = 32'd0;
        end
    end

    always_comb
    begin
        value_next = 32'd0;
        status_next = mfd_pkg::STATUS_OK;
        case (mfd_pkg::fmt_t'(action))
            mfd_pkg::FMT_F32:  value_next = source_bits;
            mfd_pkg::FMT_F16:  value_next = mfd_pkg::dec_f16(source_bits[15:0]);
            mfd_pkg::FMT_BF16: value_next = {source_bits[15:0], 16'd0};
            mfd_pkg::FMT_I32:  value_next = i32_val;
            mfd_pkg::FMT_E4M3: value_next = mfd_pkg::dec_e4m3(source_bits[7:0]);
            mfd_pkg::FMT_E8M0: value_next = mfd_pkg::dec_e8m0(source_bits[7:0]);
            default:           status_next = mfd_pkg::STATUS_UNSUPPORTED;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        status_reg <= status_next;
    end

    assign done = done_reg;
    assign value_bits = value_reg;
    assign status = status_reg;

endmodule

>>> design/mfd_checker.sv
// Port-level checker for the decoder core, with its bind statement.
// Depends on mfd_pkg and the top-level ports.
module mfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [2:0]  action,
    input logic        done,
    input logic [31:0] value_bits,
    input logic        status
);

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done) else $error("missing result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done) else $error("spurious result");

    a_unsup_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == mfd_pkg::STATUS_UNSUPPORTED) |-> value_bits == 32'd0)
        else $error("unsupported value not zero");

    a_status_map: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == mfd_pkg::FMT_RSV6 || action == mfd_pkg::FMT_RSV7)) |=>
        status == mfd_pkg::STATUS_UNSUPPORTED) else $error("status wrong");

endmodule

bind multi_format_to_binary32_decoder_core mfd_checker u_mfd_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .action(action),
    .done(done), .value_bits(value_bits), .status(status)
);

>>> tb/decoder_checker.sv
// Checker for the multi-format to binary32 decoder: predicts each result and compares it.
// Watches the start and done channels of the core; depends on mfd_pkg.
module decoder_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  action,
    input  logic [31:0] source_bits,
    input  logic        done,
    input  logic [31:0] value_bits,
    input  logic        status,
    output int          fail_count,
    output int          pending_count,
    output int          result_count
);

    typedef struct packed {
        logic [31:0] value;
        logic        stat;
    } decoded_t;

    decoded_t expected_q[$];

    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic [31:0] sgn;
        logic [4:0]  e;
        logic [10:0] m;
        logic [7:0]  shift;
        sgn = {h[15], 31'd0};
        e = h[14:10];
        m = {1'b0, h[9:0]};
        shift = 8'd0;
        if (e == 5'd0) begin
            if (m == 11'd0)
                return sgn;
            while (m[10] == 1'b0) begin
                m = m << 1;
                shift++;
            end
            return sgn | {1'b0, 8'd113 - shift, m[9:0], 13'd0};
        end
        if (e == 5'h1f)
            return sgn | mfd_pkg::EXP_ALL | {9'd0, m[9:0], 13'd0}
                   | ((m != 0) ? mfd_pkg::QUIET_BIT : 32'd0);
        return sgn | {1'b0, 8'(e) + 8'd112, m[9:0], 13'd0};
    endfunction

    function automatic logic [31:0] round_int(input logic [31:0] v);
        logic [31:0] mag, q, rem, half;
        int p, sh;
        mag = v[31] ? (32'd0 - v) : v;
        if (mag == 0)
            return 32'd0;
        p = 31;
        while (mag[p] == 1'b0)
            p--;
        if (p <= 23) begin
            q = mag << (23 - p);
        end else begin
            sh = p - 23;
            rem = mag & ((32'd1 << sh) - 1);
            half = 32'd1 << (sh - 1);
            q = mag >> sh;
            if (rem > half || (rem == half && q[0]))
                q++;
        end
        // The hidden bit in q adds into the exponent, as does a rounding carry.
        return {v[31], 31'd0} | ((32'(126 + p) << 23) + q);
    endfunction

    function automatic logic [31:0] widen_fp8(input logic [7:0] b);
        logic [31:0] sgn;
        logic [3:0]  m;
        logic [7:0]  shift;
        sgn = {b[7], 31'd0};
        m = {1'b0, b[2:0]};
        shift = 8'd0;
        if (b[6:0] == 7'd0)
            return sgn;
        if (b[6:0] == 7'h7f)
            return mfd_pkg::CANON_QNAN;
        if (b[6:3] == 4'd0) begin
            while (m[3] == 1'b0) begin
                m = m << 1;
                shift++;
            end
            return sgn | {1'b0, 8'd121 - shift, m[2:0], 20'd0};
        end
        return sgn | {1'b0, 8'(b[6:3]) + 8'd120, b[2:0], 20'd0};
    endfunction

    function automatic decoded_t decode_item(input logic [2:0] fmt, input logic [31:0] src);
        decoded_t r;
        r.stat = mfd_pkg::STATUS_OK;
        case (mfd_pkg::fmt_t'(fmt))
            mfd_pkg::FMT_F32:  r.value = src;
            mfd_pkg::FMT_F16:  r.value = widen_half(src[15:0]);
            mfd_pkg::FMT_BF16: r.value = {src[15:0], 16'd0};
            mfd_pkg::FMT_I32:  r.value = round_int(src);
            mfd_pkg::FMT_E4M3: r.value = widen_fp8(src[7:0]);
            mfd_pkg::FMT_E8M0: r.value = (src[7:0] == 8'hff) ? mfd_pkg::CANON_QNAN :
                                         (src[7:0] == 8'd0) ? mfd_pkg::QUIET_BIT :
                                         {1'b0, src[7:0], 23'd0};
            default:
            begin
                r.value = 32'd0;
                r.stat = mfd_pkg::STATUS_UNSUPPORTED;
            end
        endcase
        return r;
    endfunction

    assign pending_count = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        decoded_t exp_r;
        int errs;
        if (!rst_n) begin
            expected_q.delete();
            fail_count <= 0;
            result_count <= 0;
        end else begin
            errs = 0;
            // A result strobe in this cycle retires an older transaction first.
            if (done) begin
                result_count <= result_count + 1;
                if (expected_q.size() == 0) begin
                    $error("unexpected result: value_bits %h status %b", value_bits, status);
                    errs++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (value_bits !== exp_r.value) begin
                        $error("value_bits: expected %h actual %h", exp_r.value, value_bits);
                        errs++;
                    end
                    if (status !== exp_r.stat) begin
                        $error("status: expected %b actual %b", exp_r.stat, status);
                        errs++;
                    end
                end
            end
            if (start && !busy)
                expected_q.push_back(decode_item(action, source_bits));
            fail_count <= fail_count + errs;
        end
    end

endmodule

>>> tb/tb.sv
// Testbench top for the multi-format to binary32 decoder: clock, reset, stimulus, verdict.
// Depends on mfd_pkg, the core and decoder_checker.
module tb;

    localparam int WATCHDOG_LIMIT = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [2:0]  action = 3'd0;
    logic [31:0] source_bits = 32'd0;
    logic        busy, done, status;
    logic [31:0] value_bits;
    int          fail_count, pending_count, result_count;
    int          idle_pct = 0;
    int          sent = 0;
    int          quiet_cycles = 0;

    always #6 clk = ~clk;

    multi_format_to_binary32_decoder_core u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .action(action),
        .source_bits(source_bits), .done(done), .value_bits(value_bits), .status(status)
    );

    decoder_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .action(action),
        .source_bits(source_bits), .done(done), .value_bits(value_bits), .status(status),
        .fail_count(fail_count), .pending_count(pending_count), .result_count(result_count)
    );

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offers one transaction, idling first with the current probability.
    // Called at a rising edge; returns at the edge that accepts the transaction.
    task automatic send_item(input logic [2:0] fmt, input logic [31:0] src);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        action <= fmt;
        source_bits <= src;
        do @(posedge clk); while (busy);
        sent++;
    endtask

    // Mostly interesting values of each format, with some fully random words.
    function automatic logic [31:0] pick_source(input logic [2:0] fmt);
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(7))
            0: r = r & 32'h0000_83ff;
            1: r = r | 32'h0000_7c00;
            2: r = {r[31:8], r[7], 4'd0, r[2:0]};
            3: r = {r[31:8], r[7], 7'h7f};
            4: r = (fmt == mfd_pkg::FMT_I32) ? (r >> $urandom_range(31)) : r;
            5: r = (fmt == mfd_pkg::FMT_I32) ? {r[31:8], 8'h80} : {r[31:8], 8'hff};
            default: ;
        endcase
        return r;
    endfunction

    initial
    begin
        logic [31:0] directed[$];
        logic [2:0]  fmt;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed = '{32'h0, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001,
                     32'h0000_7c01, 32'h0000_fc00, 32'h0000_03ff, 32'h0000_007f,
                     32'h0000_00ff, 32'h0100_0001, 32'h0100_0003, 32'h0000_8001};
        foreach (directed[i])
            for (int f = 0; f < 8; f += (i < 6) ? 1 : 3)
                if (sent < 25)
                    send_item(3'(f), directed[i]);
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = (phase == 1) ? 66 : (phase == 3) ? 28 : 0;
            for (int n = 0; n < 340; n++) begin
                fmt = 3'($urandom_range(7));
                send_item(fmt, pick_source(fmt));
            end
        end
        start <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        $display("sent %0d transactions over all formats, %0d results checked", sent,
                 result_count);
        $display("phases ran with no idling and with sender gaps of 66 and 28 percent");
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> sim.f
design/mfd_pkg.sv
design/multi_format_to_binary32_decoder_core.sv
design/mfd_checker.sv
tb/decoder_checker.sv
tb/tb.sv
